>>> hdl/quaternion_error_and_body_rotation_defines.svh
`ifndef QUATERNION_ERROR_AND_BODY_ROTATION_DEFINES_SVH
`define QUATERNION_ERROR_AND_BODY_ROTATION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QEBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define QEBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define QEBR_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/qebr_pkg.sv
package qebr_pkg;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    localparam int QMUL_LAT = 4;
    localparam int ROT_LAT  = 6;

    // register stages of qebr_qnorm
    function automatic int qn_lat(input int iw, input int qf);
        return iw + 2 * qf + 7;
    endfunction

endpackage

>>> hdl/qebr_qnorm.sv
module qebr_qnorm
    import qebr_pkg::*;
#(
    parameter int IW = 16,
    parameter int QF = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pipe_ctl_t            ctl,
    input  logic [3:0][IW-1:0]   q_in,
    output logic                 out_valid,
    output logic [3:0][QF+1:0]   q_out
);

    localparam int SW  = 2 * IW + 1;
    localparam int RTW = IW + QF + 1;
    localparam int RDW = 2 * RTW;
    localparam int DW  = IW + 2 * QF + 1;
    localparam int QB  = QF + 2;
    localparam int CW  = RTW + QB;
    localparam logic [QB-1:0] QONE = {2'b01, {QF{1'b0}}};

    // squares
    logic                   v0_reg;
    logic [3:0][IW-1:0]     mag0_reg, mag0_next;
    logic [3:0]             sgn0_reg, sgn0_next;
    logic [3:0][2*IW-1:0]   sq0_reg, sq0_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sgn0_next[i] = q_in[i][IW-1];
            mag0_next[i] = q_in[i][IW-1] ? (~q_in[i] + IW'(1)) : q_in[i];
            sq0_next[i]  = (2*IW)'(mag0_next[i]) * (2*IW)'(mag0_next[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (ctl.en) begin
            v0_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            mag0_reg <= mag0_next;
            sgn0_reg <= sgn0_next;
            sq0_reg  <= sq0_next;
        end
    end

    // sum of squares, then root digit stages
    logic                   sv_reg   [RTW+1];
    logic [RDW-1:0]         rad_reg  [RTW+1];
    logic [RTW:0]           rem_reg  [RTW+1];
    logic [RTW-1:0]         root_reg [RTW+1];
    logic [3:0][IW-1:0]     smag_reg [RTW+1];
    logic [3:0]             ssgn_reg [RTW+1];
    logic [SW-1:0]          sum_next;

    assign sum_next = SW'(sq0_reg[0]) + SW'(sq0_reg[1]) + SW'(sq0_reg[2]) + SW'(sq0_reg[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg[0] <= 1'b0;
        end else if (ctl.en) begin
            sv_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            rad_reg[0]  <= {1'b0, sum_next, {(2*QF){1'b0}}};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            smag_reg[0] <= mag0_reg;
            ssgn_reg[0] <= sgn0_reg;
        end
    end

    for (genvar k = 0; k < RTW; k++) begin : g_sqrt
        logic [RTW+2:0] rem2;
        logic [RTW+2:0] trial;
        logic [RTW+2:0] diff;
        logic           ge;

        always_comb begin
            rem2  = {rem_reg[k], rad_reg[k][RDW-1 -: 2]};
            trial = {1'b0, root_reg[k], 2'b01};
            diff  = rem2 - trial;
            ge    = (rem2 >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k+1] <= 1'b0;
            end else if (ctl.en) begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                rad_reg[k+1]  <= rad_reg[k] << 2;
                rem_reg[k+1]  <= ge ? diff[RTW:0] : rem2[RTW:0];
                root_reg[k+1] <= {root_reg[k][RTW-2:0], ge};
                smag_reg[k+1] <= smag_reg[k];
                ssgn_reg[k+1] <= ssgn_reg[k];
            end
        end
    end

    // dividend prep, then one quotient bit per stage
    logic                   dv_reg   [QB+1];
    logic [RTW-1:0]         dn_reg   [QB+1];
    logic                   dz_reg   [QB+1];
    logic [3:0]             dsgn_reg [QB+1];
    logic [3:0][DW-1:0]     drem_reg [QB+1];
    logic [3:0][QB-1:0]     quo_reg  [QB+1];
    logic [3:0][DW-1:0]     d_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d_next[i] = DW'({smag_reg[RTW][i], {(2*QF){1'b0}}})
                      + DW'(root_reg[RTW] >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (ctl.en) begin
            dv_reg[0] <= sv_reg[RTW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            dn_reg[0]   <= root_reg[RTW];
            dz_reg[0]   <= (root_reg[RTW] == '0);
            dsgn_reg[0] <= ssgn_reg[RTW];
            drem_reg[0] <= d_next;
            quo_reg[0]  <= '0;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic [CW-1:0]          sh;
        logic [3:0][DW-1:0]     rem_next;
        logic [3:0][QB-1:0]     quo_next;
        logic [CW-1:0]          remx;
        logic [CW-1:0]          diff;
        logic                   ge;

        always_comb begin
            sh       = CW'(dn_reg[j]) << B;
            rem_next = drem_reg[j];
            quo_next = quo_reg[j];
            remx     = '0;
            diff     = '0;
            ge       = 1'b0;
            for (int i = 0; i < 4; i++) begin
                remx        = CW'(drem_reg[j][i]);
                diff        = remx - sh;
                ge          = (remx >= sh);
                rem_next[i] = ge ? diff[DW-1:0] : drem_reg[j][i];
                quo_next[i] = {quo_reg[j][i][QB-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (ctl.en) begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                dn_reg[j+1]   <= dn_reg[j];
                dz_reg[j+1]   <= dz_reg[j];
                dsgn_reg[j+1] <= dsgn_reg[j];
                drem_reg[j+1] <= rem_next;
                quo_reg[j+1]  <= quo_next;
            end
        end
    end

    // clamp to one and restore sign; zero quaternion stays zero
    logic                   ov_reg;
    logic [3:0][QB-1:0]     qo_reg, qo_next;
    logic [QB-1:0]          r;

    always_comb begin
        r = '0;
        for (int i = 0; i < 4; i++) begin
            r = (quo_reg[QB][i] > QONE) ? QONE : quo_reg[QB][i];
            if (dz_reg[QB]) begin
                qo_next[i] = '0;
            end else if (dsgn_reg[QB][i]) begin
                qo_next[i] = ~r + QB'(1);
            end else begin
                qo_next[i] = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (ctl.en) begin
            ov_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            qo_reg <= qo_next;
        end
    end

    assign out_valid = ov_reg;
    assign q_out     = qo_reg;

endmodule

>>> hdl/qebr_qmul.sv
module qebr_qmul
    import qebr_pkg::*;
#(
    parameter int QW = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pipe_ctl_t            ctl,
    input  logic [3:0][QW-1:0]   tn,
    input  logic [3:0][QW-1:0]   cn,
    output logic                 out_valid,
    output logic [3:0][QW+1:0]   e_out
);

    localparam int QF  = QW - 2;
    localparam int SMW = 2 * QW + 2;
    localparam logic [SMW-1:0] HALF = SMW'(1) << (QF - 1);

    // all sixteen cross products
    logic                       v1_reg;
    logic signed [2*QW-1:0]     p_reg  [4][4];
    logic signed [2*QW-1:0]     p_next [4][4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                p_next[i][j] = $signed(tn[i]) * $signed(cn[j]);
            end
        end
    end

    // conj(t) * c, order x y z w
    logic                       v2_reg;
    logic signed [SMW-1:0]      s_reg  [4];
    logic signed [SMW-1:0]      s_next [4];

    always_comb begin
        s_next[0] = SMW'(p_reg[3][0]) - SMW'(p_reg[0][3]) - SMW'(p_reg[1][2])
                  + SMW'(p_reg[2][1]);
        s_next[1] = SMW'(p_reg[3][1]) + SMW'(p_reg[0][2]) - SMW'(p_reg[1][3])
                  - SMW'(p_reg[2][0]);
        s_next[2] = SMW'(p_reg[3][2]) - SMW'(p_reg[0][1]) + SMW'(p_reg[1][0])
                  - SMW'(p_reg[2][3]);
        s_next[3] = SMW'(p_reg[3][3]) + SMW'(p_reg[0][0]) + SMW'(p_reg[1][1])
                  + SMW'(p_reg[2][2]);
    end

    // round half away from zero
    logic                       v3_reg;
    logic [3:0][QW:0]           rm_reg, rm_next;
    logic [3:0]                 rs_reg, rs_next;
    logic [SMW-1:0]             mag, rsum;

    always_comb begin
        mag  = '0;
        rsum = '0;
        for (int i = 0; i < 4; i++) begin
            rs_next[i] = s_reg[i][SMW-1];
            mag        = s_reg[i][SMW-1] ? (~s_reg[i] + SMW'(1)) : s_reg[i];
            rsum       = mag + HALF;
            rm_next[i] = rsum[QF+QW:QF];
        end
    end

    // hemisphere fix
    logic                       v4_reg;
    logic [3:0][QW+1:0]         e_reg, e_next;
    logic                       neg;

    always_comb begin
        neg = rs_reg[3] && (rm_reg[3] != '0);
        for (int i = 0; i < 4; i++) begin
            e_next[i] = (rs_reg[i] ^ neg) ? (~{1'b0, rm_reg[i]} + (QW+2)'(1))
                                          : {1'b0, rm_reg[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ctl.en) begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            p_reg  <= p_next;
            s_reg  <= s_next;
            rm_reg <= rm_next;
            rs_reg <= rs_next;
            e_reg  <= e_next;
        end
    end

    assign out_valid = v4_reg;
    assign e_out     = e_reg;

endmodule

>>> hdl/qebr_rotate.sv
module qebr_rotate
    import qebr_pkg::*;
#(
    parameter int QW   = 16,
    parameter int VW   = 24,
    parameter int TAIL = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pipe_ctl_t            ctl,
    input  logic [3:0][QW-1:0]   c_in,
    input  logic [2:0][VW-1:0]   v_in,
    output logic                 out_valid,
    output logic [2:0][VW-1:0]   body_out
);

    localparam int QF   = QW - 2;
    localparam int PW   = QW + VW;
    localparam int UVW  = PW + 1;
    localparam int P2W  = QW + UVW;
    localparam int TW   = P2W + 3;
    localparam int RMW  = TW - 2 * QF;
    localparam int SUMW = VW + 10;
    localparam logic [TW-1:0] HALF = TW'(1) << (2 * QF - 1);
    localparam logic signed [SUMW-1:0] VMAX = SUMW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] VMIN = -VMAX - SUMW'(1);

    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [3:0][QW-1:0]     c1_reg, c2_reg;
    logic [2:0][VW-1:0]     w1_reg, w2_reg, w3_reg, w4_reg, w5_reg;

    // c x v partial products; u x v = -(c x v)
    logic signed [PW-1:0]   pa_reg [3], pb_reg [3], pa_next [3], pb_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pa_next[k] = $signed(c_in[(k+2)%3]) * $signed(v_in[(k+1)%3]);
            pb_next[k] = $signed(c_in[(k+1)%3]) * $signed(v_in[(k+2)%3]);
        end
    end

    logic signed [UVW-1:0]  uv_reg [3], uv_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            uv_next[k] = UVW'(pa_reg[k]) - UVW'(pb_reg[k]);
        end
    end

    logic signed [P2W-1:0]  su_reg [3], ma_reg [3], mb_reg [3];
    logic signed [P2W-1:0]  su_next [3], ma_next [3], mb_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            su_next[k] = $signed(c2_reg[3]) * uv_reg[k];
            ma_next[k] = $signed(c2_reg[(k+2)%3]) * uv_reg[(k+1)%3];
            mb_next[k] = $signed(c2_reg[(k+1)%3]) * uv_reg[(k+2)%3];
        end
    end

    logic signed [TW-1:0]   t_reg [3], t_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t_next[k] = (TW'(su_reg[k]) + TW'(ma_reg[k]) - TW'(mb_reg[k])) <<< 1;
        end
    end

    logic [2:0][RMW-1:0]    rm_reg, rm_next;
    logic [2:0]             rs_reg, rs_next;
    logic [TW-1:0]          tmag, tsum;

    always_comb begin
        tmag = '0;
        tsum = '0;
        for (int k = 0; k < 3; k++) begin
            rs_next[k] = t_reg[k][TW-1];
            tmag       = t_reg[k][TW-1] ? (~t_reg[k] + TW'(1)) : t_reg[k];
            tsum       = tmag + HALF;
            rm_next[k] = tsum[TW-1:2*QF];
        end
    end

    logic [2:0][VW-1:0]     b_next;
    logic signed [SUMW-1:0] radd, bsum, bclamp;

    always_comb begin
        radd   = '0;
        bsum   = '0;
        bclamp = '0;
        for (int k = 0; k < 3; k++) begin
            radd = rs_reg[k] ? -$signed(SUMW'(rm_reg[k])) : $signed(SUMW'(rm_reg[k]));
            bsum = SUMW'($signed(w5_reg[k])) + radd;
            if (bsum > VMAX) begin
                bclamp = VMAX;
            end else if (bsum < VMIN) begin
                bclamp = VMIN;
            end else begin
                bclamp = bsum;
            end
            b_next[k] = bclamp[VW-1:0];
        end
    end

    // alignment line
    logic                   dv_reg [TAIL+1];
    logic [2:0][VW-1:0]     db_reg [TAIL+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
        end else if (ctl.en) begin
            v1_reg    <= ctl.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            c1_reg    <= c_in;
            c2_reg    <= c1_reg;
            w1_reg    <= v_in;
            w2_reg    <= w1_reg;
            w3_reg    <= w2_reg;
            w4_reg    <= w3_reg;
            w5_reg    <= w4_reg;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            uv_reg    <= uv_next;
            su_reg    <= su_next;
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            t_reg     <= t_next;
            rm_reg    <= rm_next;
            rs_reg    <= rs_next;
            db_reg[0] <= b_next;
        end
    end

    for (genvar d = 0; d < TAIL; d++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[d+1] <= 1'b0;
            end else if (ctl.en) begin
                dv_reg[d+1] <= dv_reg[d];
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                db_reg[d+1] <= db_reg[d];
            end
        end
    end

    assign out_valid = dv_reg[TAIL];
    assign body_out  = db_reg[TAIL];

endmodule

>>> hdl/quaternion_error_and_body_rotation.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_tgt_x..w, s_cur_x..w, s_vec_x..z
// m_        out  m_valid/m_ready    m_err_x..w, m_body_x..z
//
// One transaction per cycle sustained while m_ready holds. Most of the
// pipeline depth lies in the three normalizers: one root bit and one
// quotient bit per stage.
// aresetn is synchronous; it clears valid bits and the skid slot only.
// A stall on m_ fills the skid slot, then freezes the whole pipeline.
module quaternion_error_and_body_rotation
    import qebr_pkg::*;
#(
    parameter int QUAT_WIDTH = 16,
    parameter int VEC_WIDTH  = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [QUAT_WIDTH-1:0] s_tgt_x,
    input  logic [QUAT_WIDTH-1:0] s_tgt_y,
    input  logic [QUAT_WIDTH-1:0] s_tgt_z,
    input  logic [QUAT_WIDTH-1:0] s_tgt_w,
    input  logic [QUAT_WIDTH-1:0] s_cur_x,
    input  logic [QUAT_WIDTH-1:0] s_cur_y,
    input  logic [QUAT_WIDTH-1:0] s_cur_z,
    input  logic [QUAT_WIDTH-1:0] s_cur_w,
    input  logic [VEC_WIDTH-1:0]  s_vec_x,
    input  logic [VEC_WIDTH-1:0]  s_vec_y,
    input  logic [VEC_WIDTH-1:0]  s_vec_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [QUAT_WIDTH-1:0] m_err_x,
    output logic [QUAT_WIDTH-1:0] m_err_y,
    output logic [QUAT_WIDTH-1:0] m_err_z,
    output logic [QUAT_WIDTH-1:0] m_err_w,
    output logic [VEC_WIDTH-1:0]  m_body_x,
    output logic [VEC_WIDTH-1:0]  m_body_y,
    output logic [VEC_WIDTH-1:0]  m_body_z
);

    localparam int QW   = QUAT_WIDTH;
    localparam int VW   = VEC_WIDTH;
    localparam int QF   = QW - 2;
    localparam int LQ   = qn_lat(QW, QF) + QMUL_LAT + qn_lat(QW + 2, QF);
    localparam int TAIL = LQ - ROT_LAT;

    logic               pipe_en;
    pipe_ctl_t          in_ctl, mul_ctl, en_ctl;
    logic [3:0][QW-1:0] tgt_q, cur_q, tn, cn, err_q;
    logic [3:0][QW+1:0] e_raw;
    logic [2:0][VW-1:0] vec_v, body_v;
    logic               vt, vc, ve, vm, vr, tail_valid;

    assign tgt_q = {s_tgt_w, s_tgt_z, s_tgt_y, s_tgt_x};
    assign cur_q = {s_cur_w, s_cur_z, s_cur_y, s_cur_x};
    assign vec_v = {s_vec_z, s_vec_y, s_vec_x};

    assign in_ctl  = '{en: pipe_en, valid: s_valid};
    assign mul_ctl = '{en: pipe_en, valid: vt & vc};
    assign en_ctl  = '{en: pipe_en, valid: vm};

    qebr_qnorm #(.IW(QW), .QF(QF)) u_norm_tgt (
        .aclk(aclk), .aresetn(aresetn), .ctl(in_ctl), .q_in(tgt_q),
        .out_valid(vt), .q_out(tn)
    );

    qebr_qnorm #(.IW(QW), .QF(QF)) u_norm_cur (
        .aclk(aclk), .aresetn(aresetn), .ctl(in_ctl), .q_in(cur_q),
        .out_valid(vc), .q_out(cn)
    );

    qebr_qmul #(.QW(QW)) u_qmul (
        .aclk(aclk), .aresetn(aresetn), .ctl(mul_ctl), .tn(tn), .cn(cn),
        .out_valid(vm), .e_out(e_raw)
    );

    qebr_qnorm #(.IW(QW + 2), .QF(QF)) u_norm_err (
        .aclk(aclk), .aresetn(aresetn), .ctl(en_ctl), .q_in(e_raw),
        .out_valid(ve), .q_out(err_q)
    );

    qebr_rotate #(.QW(QW), .VW(VW), .TAIL(TAIL)) u_rotate (
        .aclk(aclk), .aresetn(aresetn), .ctl(in_ctl), .c_in(cur_q), .v_in(vec_v),
        .out_valid(vr), .body_out(body_v)
    );

    assign tail_valid = ve & vr;

    // output register plus skid slot
    logic               m_valid_reg, skid_valid_reg;
    logic [3:0][QW-1:0] m_err_reg, skid_err_reg;
    logic [2:0][VW-1:0] m_body_reg, skid_body_reg;
    logic               out_free, take;

    assign pipe_en  = ~skid_valid_reg;
    assign out_free = ~m_valid_reg | m_ready;
    assign take     = pipe_en & tail_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg    <= skid_valid_reg | take;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_err_reg  <= skid_err_reg;
                m_body_reg <= skid_body_reg;
            end else if (take) begin
                m_err_reg  <= err_q;
                m_body_reg <= body_v;
            end
        end else if (take) begin
            skid_err_reg  <= err_q;
            skid_body_reg <= body_v;
        end
    end

    assign s_ready  = pipe_en;
    assign m_valid  = m_valid_reg;
    assign m_err_x  = m_err_reg[0];
    assign m_err_y  = m_err_reg[1];
    assign m_err_z  = m_err_reg[2];
    assign m_err_w  = m_err_reg[3];
    assign m_body_x = m_body_reg[0];
    assign m_body_y = m_body_reg[1];
    assign m_body_z = m_body_reg[2];

endmodule

>>> hdl/qebr_chk.sv
`include "quaternion_error_and_body_rotation_defines.svh"

module qebr_chk #(
    parameter int QUAT_WIDTH = 16,
    parameter int VEC_WIDTH  = 24
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [QUAT_WIDTH-1:0] m_err_x,
    input logic [QUAT_WIDTH-1:0] m_err_w,
    input logic [VEC_WIDTH-1:0]  m_body_x
);

    localparam logic signed [QUAT_WIDTH-1:0] QONE = {2'b01, {(QUAT_WIDTH-2){1'b0}}};

    `QEBR_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped")
    `QEBR_ASSERT_NXT(a_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_err_x) && $stable(m_body_x), "payload moved")
    `QEBR_ASSERT_NOW(a_err_w, aclk, aresetn, m_valid, !m_err_w[QUAT_WIDTH-1] && ($signed(m_err_w) <= QONE), "err_w out of range")
    `QEBR_ASSERT_NOW(a_err_x, aclk, aresetn, m_valid, ($signed(m_err_x) <= QONE) && ($signed(m_err_x) >= -QONE), "err_x out of range")
    `QEBR_ASSERT_RST(a_rst_rdy, aclk, !aresetn, s_ready, "not ready after reset")

endmodule

bind quaternion_error_and_body_rotation qebr_chk #(
    .QUAT_WIDTH(QUAT_WIDTH),
    .VEC_WIDTH(VEC_WIDTH)
) u_qebr_chk (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_err_x(m_err_x),
    .m_err_w(m_err_w),
    .m_body_x(m_body_x)
);

>>> tb/sv/tb_top.sv
module tb_top;

    localparam int QW = 16;
    localparam int VW = 24;
    localparam int QF = QW - 2;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 6 * QW + 13 + 20;

    typedef struct {
        logic signed [QW-1:0] tgt[4];
        logic signed [QW-1:0] cur[4];
        logic signed [VW-1:0] vec[3];
    } attitude_t;

    typedef struct packed {
        logic signed [QW-1:0] err_x, err_y, err_z, err_w;
        logic signed [VW-1:0] body_x, body_y, body_z;
    } attitude_err_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [QW-1:0] s_tgt_x = '0, s_tgt_y = '0, s_tgt_z = '0, s_tgt_w = '0;
    logic [QW-1:0] s_cur_x = '0, s_cur_y = '0, s_cur_z = '0, s_cur_w = '0;
    logic [VW-1:0] s_vec_x = '0, s_vec_y = '0, s_vec_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [QW-1:0] m_err_x, m_err_y, m_err_z, m_err_w;
    logic [VW-1:0] m_body_x, m_body_y, m_body_z;

    attitude_err_t pending_err_q[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int rx_cycle = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    quaternion_error_and_body_rotation #(.QUAT_WIDTH(QW), .VEC_WIDTH(VW)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_tgt_x(s_tgt_x), .s_tgt_y(s_tgt_y), .s_tgt_z(s_tgt_z), .s_tgt_w(s_tgt_w),
        .s_cur_x(s_cur_x), .s_cur_y(s_cur_y), .s_cur_z(s_cur_z), .s_cur_w(s_cur_w),
        .s_vec_x(s_vec_x), .s_vec_y(s_vec_y), .s_vec_z(s_vec_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_err_x(m_err_x), .m_err_y(m_err_y), .m_err_z(m_err_z), .m_err_w(m_err_w),
        .m_body_x(m_body_x), .m_body_y(m_body_y), .m_body_z(m_body_z)
    );

    function automatic longint unsigned magnitude(input longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    function automatic longint round_shift(input longint a, input int k);
        longint unsigned m;
        m = (magnitude(a) + (64'd1 << (k - 1))) >> k;
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned a);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > a) b = b >> 2;
        while (b != 0) begin
            if (a >= r + b) begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void normalize_quat(input longint q[4], output longint o[4]);
        longint unsigned sumsq, n, r;
        sumsq = 0;
        for (int i = 0; i < 4; i++) sumsq += magnitude(q[i]) * magnitude(q[i]);
        if (sumsq == 0) begin
            o = q;
            return;
        end
        n = int_sqrt(sumsq << (2 * QF));
        for (int i = 0; i < 4; i++) begin
            r = ((magnitude(q[i]) << (2 * QF)) + n / 2) / n;
            if (r > (64'd1 << QF)) r = 64'd1 << QF;
            o[i] = (q[i] < 0) ? -longint'(r) : longint'(r);
        end
    endfunction

    function automatic longint sat_vec(input longint a);
        longint hi, lo;
        hi = (64'sd1 <<< (VW - 1)) - 1;
        lo = -hi - 1;
        return (a > hi) ? hi : ((a < lo) ? lo : a);
    endfunction

    function automatic attitude_err_t predict_attitude_err(input attitude_t it);
        longint t[4], c[4], tn[4], cn[4], e[4], en[4], v[3];
        longint ux, uy, uz, sw, uvx, uvy, uvz, uuvx, uuvy, uuvz;
        attitude_err_t r;
        for (int i = 0; i < 4; i++) begin
            t[i] = longint'(it.tgt[i]);
            c[i] = longint'(it.cur[i]);
        end
        for (int i = 0; i < 3; i++) v[i] = longint'(it.vec[i]);
        normalize_quat(t, tn);
        normalize_quat(c, cn);
        e[0] = round_shift(tn[3]*cn[0] - tn[0]*cn[3] - tn[1]*cn[2] + tn[2]*cn[1], QF);
        e[1] = round_shift(tn[3]*cn[1] + tn[0]*cn[2] - tn[1]*cn[3] - tn[2]*cn[0], QF);
        e[2] = round_shift(tn[3]*cn[2] - tn[0]*cn[1] + tn[1]*cn[0] - tn[2]*cn[3], QF);
        e[3] = round_shift(tn[3]*cn[3] + tn[0]*cn[0] + tn[1]*cn[1] + tn[2]*cn[2], QF);
        if (e[3] < 0) for (int i = 0; i < 4; i++) e[i] = -e[i];
        normalize_quat(e, en);
        ux = -c[0]; uy = -c[1]; uz = -c[2]; sw = c[3];
        uvx = uy * v[2] - uz * v[1];
        uvy = uz * v[0] - ux * v[2];
        uvz = ux * v[1] - uy * v[0];
        uuvx = uy * uvz - uz * uvy;
        uuvy = uz * uvx - ux * uvz;
        uuvz = ux * uvy - uy * uvx;
        r.err_x = en[0][QW-1:0];
        r.err_y = en[1][QW-1:0];
        r.err_z = en[2][QW-1:0];
        r.err_w = en[3][QW-1:0];
        r.body_x = VW'(sat_vec(v[0] + round_shift(2 * (sw * uvx + uuvx), 2 * QF)));
        r.body_y = VW'(sat_vec(v[1] + round_shift(2 * (sw * uvy + uuvy), 2 * QF)));
        r.body_z = VW'(sat_vec(v[2] + round_shift(2 * (sw * uvz + uuvz), 2 * QF)));
        return r;
    endfunction

    // receiver stall pattern rotates through four modes, selected by rx_cycle
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle >> 8) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= ((rx_cycle % 9) < 3);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge aclk) begin
        attitude_err_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_err_x, m_err_y, m_err_z, m_err_w, m_body_x, m_body_y, m_body_z};
            if (pending_err_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %p", got);
            end else begin
                want = pending_err_q.pop_front();
                if (got.err_x !== want.err_x || got.err_y !== want.err_y ||
                    got.err_z !== want.err_z || got.err_w !== want.err_w ||
                    got.body_x !== want.body_x || got.body_y !== want.body_y ||
                    got.body_z !== want.body_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input attitude_t it);
        s_valid <= 1'b1;
        s_tgt_x <= it.tgt[0]; s_tgt_y <= it.tgt[1];
        s_tgt_z <= it.tgt[2]; s_tgt_w <= it.tgt[3];
        s_cur_x <= it.cur[0]; s_cur_y <= it.cur[1];
        s_cur_z <= it.cur[2]; s_cur_w <= it.cur[3];
        s_vec_x <= it.vec[0]; s_vec_y <= it.vec[1]; s_vec_z <= it.vec[2];
        do @(posedge aclk); while (!s_ready);
        pending_err_q.push_back(predict_attitude_err(it));
    endtask

    task automatic pause_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    function automatic attitude_t make_item(input logic signed [QW-1:0] t[4],
                                            input logic signed [QW-1:0] c[4],
                                            input logic signed [VW-1:0] v[3]);
        attitude_t it;
        it.tgt = t;
        it.cur = c;
        it.vec = v;
        return it;
    endfunction

    function automatic logic signed [QW-1:0] rand_quat_part();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return $signed(16'($urandom)) >>> $urandom_range(1, 12);
            3: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [VW-1:0] rand_vec_part();
        case ($urandom_range(0, 3))
            0: return $signed(24'($urandom)) >>> $urandom_range(1, 20);
            1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [QW-1:0] z4[4], id4[4], neg4[4], mx4[4], mn4[4], x4[4], h4[4];
        logic signed [VW-1:0] v0[3], vmx[3], vmn[3], v1[3];
        z4 = '{0, 0, 0, 0};
        id4 = '{0, 0, 0, 16384};
        neg4 = '{0, 0, 0, -16384};
        mx4 = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        mn4 = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        x4 = '{16384, 0, 0, 0};
        h4 = '{11585, 0, 0, 11585};
        v0 = '{0, 0, 0};
        vmx = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff};
        vmn = '{24'sh800000, 24'sh800000, 24'sh800000};
        v1 = '{65536, -131072, 32768};
        send_item(make_item(id4, id4, v1));
        send_item(make_item(z4, id4, v1));
        send_item(make_item(id4, z4, v1));
        send_item(make_item(z4, z4, vmx));
        send_item(make_item(id4, neg4, v1));
        send_item(make_item(id4, x4, v1));
        send_item(make_item(x4, id4, vmn));
        send_item(make_item(mx4, mn4, vmx));
        send_item(make_item(mn4, mx4, vmn));
        send_item(make_item(mx4, mx4, vmx));
        send_item(make_item(mn4, mn4, vmn));
        send_item(make_item(h4, x4, v1));
        send_item(make_item(x4, h4, v0));
        send_item(make_item(neg4, mx4, vmx));
        send_item(make_item(h4, mn4, vmn));
        pause_sender(3);
    endtask

    task automatic test_random(input int count);
        attitude_t it;
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 4; i++) begin
                it.tgt[i] = rand_quat_part();
                it.cur[i] = rand_quat_part();
            end
            for (int i = 0; i < 3; i++) it.vec[i] = rand_vec_part();
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if (n > count / 3 && n < count / 2) burst = count;
                else pause_sender($urandom_range(1, 8));
            end
            send_item(it);
            burst--;
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(850);
        while (pending_err_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/qebr_pkg.sv
hdl/qebr_qnorm.sv
hdl/qebr_qmul.sv
hdl/qebr_rotate.sv
hdl/quaternion_error_and_body_rotation.sv
hdl/qebr_chk.sv
tb/sv/tb_top.sv
